// ===== rtl/core/apio_pkg.sv =====
package apio_pkg;

  localparam int SAMPLE_STORE_DEPTH = 16384;
  localparam int SS_AW = $clog2(SAMPLE_STORE_DEPTH);
  localparam int NUM_SOUNDS = 10;

  // func codes
  localparam logic [2:0] FN_PORT_READ  = 3'd0;
  localparam logic [2:0] FN_PORT_WRITE = 3'd1;
  localparam logic [2:0] FN_KEY_DOWN   = 3'd2;
  localparam logic [2:0] FN_KEY_UP     = 3'd3;
  localparam logic [2:0] FN_TICK       = 3'd4;
  localparam logic [2:0] FN_STORE      = 3'd5;
  localparam logic [2:0] FN_DESC       = 3'd6;

  // port numbers
  localparam logic [7:0] PORT_CONST    = 8'd0;
  localparam logic [7:0] PORT_P1       = 8'd1;
  localparam logic [7:0] PORT_P2       = 8'd2;
  localparam logic [7:0] PORT_SHIFT    = 8'd3;
  localparam logic [7:0] PORT_AMOUNT   = 8'd2;
  localparam logic [7:0] PORT_SOUND_A  = 8'd3;
  localparam logic [7:0] PORT_SHIFT_IN = 8'd4;
  localparam logic [7:0] PORT_SOUND_B  = 8'd5;

  localparam logic [7:0] PORT0_VALUE = 8'h0f;
  localparam logic [2:0] AMOUNT_MASK = 3'h7;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  port;
    logic [7:0]  data;
    logic [3:0]  key;
    logic [13:0] rom_address;
    logic [3:0]  sound_index;
    logic [14:0] sound_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic signed [15:0] sample;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_STORE  = 3'd0,
    OP_DESC   = 3'd1,
    OP_PORT_A = 3'd2,
    OP_PORT_B = 3'd3,
    OP_TICK   = 3'd4
  } snd_op_t;

  typedef struct packed {
    logic        start;
    snd_op_t     op;
    logic [7:0]  data;
    logic [13:0] rom_address;
    logic [3:0]  sound_index;
    logic [14:0] sound_length;
  } snd_cmd_t;

  typedef struct packed {
    logic               done;
    logic signed [15:0] sample;
  } snd_stat_t;

endpackage

// ===== rtl/core/apio_sound.sv =====
module apio_sound import apio_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  snd_cmd_t  cmd,
  output snd_stat_t stat
);

  localparam logic [1:0] CH_EFFECTS = 2'd0;
  localparam logic [1:0] CH_BASEHIT = 2'd1;
  localparam logic [1:0] CH_WALK    = 2'd2;
  localparam logic [1:0] CH_UFO     = 2'd3;
  localparam logic [2:0] LAST_TRIG  = 3'd4;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_TRIG  = 5'b00010,
    S_TICK  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  typedef struct packed {
    logic [1:0] ch;
    logic [3:0] snd;
  } trig_t;

  // Trigger order per sound port; later entries override earlier ones on a channel.
  function automatic trig_t trig_map(input logic port_b, input logic [2:0] step);
    trig_t t;
    t = '{ch: CH_EFFECTS, snd: 4'd0};
    if (!port_b) begin
      case (step)
        3'd0:    t = '{ch: CH_UFO,     snd: 4'd0};
        3'd1:    t = '{ch: CH_EFFECTS, snd: 4'd1};
        3'd2:    t = '{ch: CH_BASEHIT, snd: 4'd2};
        3'd3:    t = '{ch: CH_EFFECTS, snd: 4'd3};
        default: t = '{ch: CH_EFFECTS, snd: 4'd4};
      endcase
    end else begin
      case (step)
        3'd0:    t = '{ch: CH_WALK,    snd: 4'd5};
        3'd1:    t = '{ch: CH_WALK,    snd: 4'd6};
        3'd2:    t = '{ch: CH_WALK,    snd: 4'd7};
        3'd3:    t = '{ch: CH_WALK,    snd: 4'd8};
        default: t = '{ch: CH_EFFECTS, snd: 4'd9};
      endcase
    end
    return t;
  endfunction

  state_t  state;
  snd_op_t op;
  logic [4:0] rise;
  logic       fall0;
  logic       port_b;
  logic [2:0] step;
  logic [1:0] cnt;
  logic       pend;
  logic signed [17:0] acc;
  logic [7:0] last_sound_port_a;
  logic [7:0] last_sound_port_b;

  logic [13:0] chan_start  [4];
  logic [14:0] chan_length [4];
  logic [14:0] chan_pos    [4];
  logic [3:0]  chan_active;

  logic [28:0] sound_table [NUM_SOUNDS];
  logic [7:0]  sample_store [SAMPLE_STORE_DEPTH];
  logic [7:0]  rd_data;

  logic [13:0] cur_start;
  logic [14:0] cur_len;
  logic [14:0] cur_pos;
  logic        cur_act;
  logic        pos_ge;
  logic [14:0] pos_eff;
  logic [14:0] pos_inc;
  logic [15:0] addr_sum;
  logic        fetch_ok;
  logic signed [17:0] term;
  logic signed [15:0] sat;
  trig_t       tr;
  logic [28:0] tr_desc;
  logic [7:0]  rise_a;
  logic [7:0]  rise_b;

  // Shared address/position unit, one channel per cycle
  always_comb begin
    cur_start = chan_start[cnt];
    cur_len   = chan_length[cnt];
    cur_pos   = chan_pos[cnt];
    cur_act   = chan_active[cnt];
    pos_ge    = cur_pos >= cur_len;
    pos_eff   = (cnt == CH_UFO && pos_ge) ? 15'd0 : cur_pos;
    addr_sum  = {2'b00, cur_start} + {1'b0, pos_eff};
    pos_inc   = pos_eff + 15'd1;
    if (cnt == CH_UFO) begin
      fetch_ok = cur_act && (cur_len != 15'd0);
    end else begin
      fetch_ok = cur_act && !pos_ge;
    end
    // (b - 128) * 128, sign-extended
    term = {{3{~rd_data[7]}}, ~rd_data[7], rd_data[6:0], 7'b0};
    if (acc > 18'sd32767) begin
      sat = 16'sh7fff;
    end else if (acc < -18'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = acc[15:0];
    end
    tr      = trig_map(port_b, step);
    tr_desc = sound_table[tr.snd];
    rise_a  = cmd.data & ~last_sound_port_a;
    rise_b  = cmd.data & ~last_sound_port_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      op                <= OP_STORE;
      rise              <= '0;
      fall0             <= 1'b0;
      port_b            <= 1'b0;
      step              <= '0;
      cnt               <= '0;
      pend              <= 1'b0;
      acc               <= '0;
      last_sound_port_a <= '0;
      last_sound_port_b <= '0;
      chan_active       <= '0;
      for (int i = 0; i < 4; i++) begin
        chan_start[i]  <= '0;
        chan_length[i] <= '0;
        chan_pos[i]    <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            op <= cmd.op;
            case (cmd.op)
              OP_PORT_A: begin
                rise              <= rise_a[4:0];
                fall0             <= ~cmd.data[0] & last_sound_port_a[0];
                port_b            <= 1'b0;
                step              <= '0;
                last_sound_port_a <= cmd.data;
                state             <= S_TRIG;
              end
              OP_PORT_B: begin
                rise              <= rise_b[4:0];
                fall0             <= 1'b0;
                port_b            <= 1'b1;
                step              <= '0;
                last_sound_port_b <= cmd.data;
                state             <= S_TRIG;
              end
              OP_TICK: begin
                cnt   <= '0;
                pend  <= 1'b0;
                acc   <= '0;
                state <= S_TICK;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_TRIG: begin
          if (fall0 && step == 3'd0) begin
            chan_active[CH_UFO] <= 1'b0;
          end
          if (rise[step]) begin
            chan_start[tr.ch]  <= tr_desc[13:0];
            chan_length[tr.ch] <= tr_desc[28:14];
            // a running loop keeps its position
            if (tr.ch != CH_UFO || !chan_active[tr.ch]) begin
              chan_pos[tr.ch] <= '0;
            end
            chan_active[tr.ch] <= 1'b1;
          end
          if (step == LAST_TRIG) begin
            state <= S_DONE;
          end
          step <= step + 3'd1;
        end
        S_TICK: begin
          if (fetch_ok) begin
            chan_pos[cnt] <= pos_inc;
          end else if (cnt != CH_UFO) begin
            chan_active[cnt] <= 1'b0;
          end
          if (pend) begin
            acc <= acc + term;
          end
          pend <= fetch_ok;
          cnt  <= cnt + 2'd1;
          if (cnt == CH_UFO) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (pend) begin
            acc <= acc + term;
          end
          pend  <= 1'b0;
          state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.start && cmd.op == OP_DESC &&
        cmd.sound_index < 4'(NUM_SOUNDS)) begin
      sound_table[cmd.sound_index] <= {cmd.sound_length, cmd.rom_address};
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && cmd.start && cmd.op == OP_STORE) begin
      sample_store[SS_AW'(cmd.rom_address)] <= cmd.data;
    end
    rd_data <= sample_store[SS_AW'(addr_sum)];
  end

  assign stat.done   = (state == S_DONE);
  assign stat.sample = (op == OP_TICK) ? sat : 16'sd0;

endmodule

// ===== rtl/core/arcade_port_io_shifter_and_sound_mixer_top.sv =====
// Arcade I/O port block with a four-channel sample mixer.
// Input channel (in_valid / in_stall / in_item) carries one operation per
// transaction: port read, port write, key down/up, sample tick, sample store
// write or sound descriptor write. Every transaction yields exactly one
// result transaction on the output channel (out_valid / out_stall / out_item).
// Port reads, key changes and writes to the shift ports complete directly:
// the result is registered at the accept edge. Sound port writes run a
// trigger sequencer over five bits, one per cycle. A sample tick walks the
// four channels through one shared address adder and the single sample
// store read port, one channel per cycle, then drains and saturates. Store
// and descriptor writes update their memory at the accept edge.
// One operation is in flight at a time; in_stall stays high until the result
// has been placed in the output register and that register is free again.
// Reset clears the latches, the shift register, the sound port history and
// all channels; the sample store and descriptor table are not cleared and
// must be loaded before use. A stalled result holds in the output register
// and blocks new transactions until taken.
module arcade_port_io_shifter_and_sound_mixer_top import apio_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  typedef enum logic [1:0] {
    T_IDLE = 2'b01,
    T_WAIT = 2'b10
  } state_t;

  state_t     state;
  logic [7:0] player_one_latch;
  logic [7:0] player_two_latch;
  logic [7:0] shift_high;
  logic [7:0] shift_low;
  logic [2:0] shift_amount;

  logic       accept;
  logic       sound_op;
  snd_cmd_t   cmd;
  snd_stat_t  stat;
  logic [7:0] read_value;
  logic [15:0] window;
  logic [7:0] key_mask;
  logic       key_two;

  assign in_stall = (state != T_IDLE) || out_valid;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    window = {shift_high, shift_low} >> (4'd8 - {1'b0, shift_amount});
    case (in_item.port)
      PORT_CONST: read_value = PORT0_VALUE;
      PORT_P1:    read_value = player_one_latch;
      PORT_P2:    read_value = player_two_latch;
      PORT_SHIFT: read_value = window[7:0];
      default:    read_value = 8'd0;
    endcase
  end

  always_comb begin
    key_two = 1'b0;
    unique case (in_item.key)
      4'd0:    key_mask = 8'h04;
      4'd1:    key_mask = 8'h20;
      4'd2:    key_mask = 8'h40;
      4'd3:    key_mask = 8'h10;
      4'd4:    key_mask = 8'h02;
      4'd5:    begin key_mask = 8'h20; key_two = 1'b1; end
      4'd6:    begin key_mask = 8'h40; key_two = 1'b1; end
      4'd7:    begin key_mask = 8'h10; key_two = 1'b1; end
      4'd8:    key_mask = 8'h01;
      default: key_mask = 8'h00;
    endcase
  end

  always_comb begin
    cmd.op = OP_TICK;
    sound_op = 1'b0;
    case (in_item.func)
      FN_PORT_WRITE: begin
        if (in_item.port == PORT_SOUND_A) begin
          cmd.op = OP_PORT_A;
          sound_op = 1'b1;
        end else if (in_item.port == PORT_SOUND_B) begin
          cmd.op = OP_PORT_B;
          sound_op = 1'b1;
        end
      end
      FN_TICK:  sound_op = 1'b1;
      FN_STORE: begin cmd.op = OP_STORE; sound_op = 1'b1; end
      FN_DESC:  begin cmd.op = OP_DESC;  sound_op = 1'b1; end
      default:  sound_op = 1'b0;
    endcase
    cmd.start        = accept && sound_op;
    cmd.data         = in_item.data;
    cmd.rom_address  = in_item.rom_address;
    cmd.sound_index  = in_item.sound_index;
    cmd.sound_length = in_item.sound_length;
  end

  apio_sound u_sound (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= T_IDLE;
      out_valid        <= 1'b0;
      player_one_latch <= '0;
      player_two_latch <= '0;
      shift_high       <= '0;
      shift_low        <= '0;
      shift_amount     <= '0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            out_item <= '{read_data: (in_item.func == FN_PORT_READ) ? read_value : 8'd0,
                          sample: 16'sd0};
            if (sound_op) begin
              state <= T_WAIT;
            end else begin
              out_valid <= 1'b1;
            end
            case (in_item.func)
              FN_PORT_WRITE: begin
                if (in_item.port == PORT_AMOUNT) begin
                  shift_amount <= in_item.data[2:0] & AMOUNT_MASK;
                end else if (in_item.port == PORT_SHIFT_IN) begin
                  shift_low  <= shift_high;
                  shift_high <= in_item.data;
                end
              end
              FN_KEY_DOWN: begin
                if (key_two) player_two_latch <= player_two_latch | key_mask;
                else         player_one_latch <= player_one_latch | key_mask;
              end
              FN_KEY_UP: begin
                if (key_two) player_two_latch <= player_two_latch & ~key_mask;
                else         player_one_latch <= player_one_latch & ~key_mask;
              end
              default: ;
            endcase
          end
        end
        T_WAIT: begin
          if (stat.done) begin
            out_item  <= '{read_data: 8'd0, sample: stat.sample};
            out_valid <= 1'b1;
            state     <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/apio_checker.sv =====
module apio_checker import apio_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // one transaction in flight: stall right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");

  a_exclusive_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.sample != 16'sd0 |-> out_item.read_data == 8'd0)
    else $error("read data and sample both nonzero");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind arcade_port_io_shifter_and_sound_mixer_top apio_checker u_apio_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
